// ----- src/lz77_token_decompressor_assert.svh -----
// Assertion macros shared by the decompressor RTL. Each clocks on clk_i and
// is disabled while rst_ni is low.
`ifndef LZ77_TOKEN_DECOMPRESSOR_ASSERT_SVH
`define LZ77_TOKEN_DECOMPRESSOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lz77d_pkg.sv -----
package lz77d_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 8192;
  localparam int unsigned STREAM_W          = 24;
  localparam int unsigned TOKEN_W           = 16;
  // Wide enough to compare a distance against a full window count.
  localparam int unsigned CMP_W             = 17;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_REJECT   = 2'd1,
    ST_BAD_DIST = 2'd2,
    ST_PAST_END = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_HDR3 = 3'd3,
    PH_LIT  = 3'd4
  } phase_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
  } out_item_t;

  // Item held between the history read and the result register.
  typedef struct packed {
    logic       wr_en;
    logic       is_copy;
    logic       fwd;
    logic [7:0] lit_byte;
    status_e    status;
  } s1_t;

endpackage

// ----- src/lz77_token_decompressor.sv -----
// LZ77 token decompressor.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries one item per
// transfer: a compressed stream byte, or a tick that emits the next byte of a
// pending copy. The output channel (out_valid_o, out_stall_i, out_data_o)
// carries zero or one result per input item, in input order: a decoded byte,
// or a status code with a zero byte.
// cfg_we_i/cfg_wdata_i set the stream length in bytes; write it while idle.
// Throughput is one item per cycle while in_stall_o is low. A result is
// registered first in the middle stage, beside the synchronous history read,
// and then in the output register. A copy byte read in the same cycle its
// source is being written (distance one) is taken from a forwarding register.
// Reset clears the parser, pointers, counters and stream length; the history
// memory is not cleared, since a copy can only reach bytes already written.
// When out_stall_i holds a result, the middle stage fills and then
// in_stall_o rises in the same cycle; nothing is lost or reordered.
module lz77_token_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lz77d_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lz77d_pkg::STREAM_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lz77d_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lz77d_pkg::out_item_t              out_data_o
);
  import lz77d_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned BW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = AW + 2;

  logic [7:0]          hist_mem_q [HISTORY_DEPTH];
  logic [7:0]          rd_data_q;
  logic [7:0]          fwd_data_q;

  logic [STREAM_W-1:0] stream_q;
  logic [STREAM_W-1:0] consumed_q, consumed_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [AW-1:0]       src_q, src_d;
  logic [AW-1:0]       wr_addr_q;
  logic [BW-1:0]       bw_q, bw_d;
  phase_e              phase_q, phase_d;
  logic [TOKEN_W-1:0]  hdist_q, hdist_d;
  logic [7:0]          hlen_lo_q, hlen_lo_d;
  logic [TOKEN_W-1:0]  lit_rem_q, lit_rem_d;
  logic [TOKEN_W-1:0]  copy_rem_q, copy_rem_d;

  logic                s1_valid_q;
  s1_t                 s1_q, s1_d;
  logic                s1_load;
  logic                out_valid_q;
  out_item_t           out_data_q;

  logic                accept, is_tick, copy_busy, past_end, hdr_take;
  logic                out_free, s1_free, wr_now, mem_rd_en, put;
  logic [7:0]          s1_val;
  logic [TOKEN_W-1:0]  full_len;
  logic                dist_bad;
  logic [SW-1:0]       src_sum;
  logic [AW-1:0]       src_start, wp_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;
  assign is_tick    = (in_data_i.cmd == CMD_TICK);
  assign copy_busy  = (copy_rem_q != '0);
  assign past_end   = (consumed_q >= stream_q);
  assign hdr_take   = accept && !is_tick && !copy_busy && !past_end;

  assign wr_now = s1_valid_q && s1_q.wr_en && out_free;
  assign s1_val = s1_q.is_copy ? (s1_q.fwd ? fwd_data_q : rd_data_q) : s1_q.lit_byte;

  assign full_len = {in_data_i.in_byte, hlen_lo_q};
  assign dist_bad = (CMP_W'(hdist_q) > CMP_W'(bw_q));
  assign wp_inc   = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;

  // Copy source starts at the write pointer minus the distance, modulo depth.
  assign src_sum   = SW'(wp_q) + SW'(HISTORY_DEPTH) - SW'(hdist_q);
  assign src_start = (src_sum >= SW'(HISTORY_DEPTH)) ?
                     AW'(src_sum - SW'(HISTORY_DEPTH)) : AW'(src_sum);

  // Next parse phase.
  always_comb begin
    phase_d = phase_q;
    if (hdr_take) begin
      unique case (phase_q)
        PH_HDR0: phase_d = PH_HDR1;
        PH_HDR1: phase_d = PH_HDR2;
        PH_HDR2: phase_d = PH_HDR3;
        PH_HDR3: phase_d = (hdist_q == '0 && full_len != '0) ? PH_LIT : PH_HDR0;
        PH_LIT:  phase_d = (lit_rem_q == TOKEN_W'(1)) ? PH_HDR0 : PH_LIT;
        default: phase_d = PH_HDR0;
      endcase
    end
  end

  // Datapath and counters.
  always_comb begin
    consumed_d = consumed_q;
    hdist_d    = hdist_q;
    hlen_lo_d  = hlen_lo_q;
    lit_rem_d  = lit_rem_q;
    copy_rem_d = copy_rem_q;
    src_d      = src_q;
    s1_load    = 1'b0;
    s1_d       = '0;
    mem_rd_en  = 1'b0;
    put        = 1'b0;

    if (accept) begin
      if (is_tick) begin
        if (copy_busy) begin
          mem_rd_en  = 1'b1;
          put        = 1'b1;
          copy_rem_d = copy_rem_q - 1'b1;
          src_d      = (src_q == AW'(HISTORY_DEPTH - 1)) ? '0 : src_q + 1'b1;
          s1_load    = 1'b1;
          s1_d.wr_en   = 1'b1;
          s1_d.is_copy = 1'b1;
          // The byte being written back this cycle is not yet in the memory.
          s1_d.fwd     = wr_now && (wr_addr_q == src_q);
          s1_d.status  = ST_DATA;
        end
      end else if (copy_busy) begin
        s1_load     = 1'b1;
        s1_d.status = ST_REJECT;
      end else if (past_end) begin
        s1_load     = 1'b1;
        s1_d.status = ST_PAST_END;
      end else begin
        consumed_d = consumed_q + 1'b1;
        unique case (phase_q)
          PH_HDR0: hdist_d[7:0]  = in_data_i.in_byte;
          PH_HDR1: hdist_d[15:8] = in_data_i.in_byte;
          PH_HDR2: hlen_lo_d     = in_data_i.in_byte;
          PH_HDR3: begin
            if (hdist_q == '0) begin
              lit_rem_d = full_len;
            end else if (dist_bad) begin
              s1_load     = 1'b1;
              s1_d.status = ST_BAD_DIST;
            end else begin
              copy_rem_d = full_len;
              src_d      = src_start;
            end
          end
          PH_LIT: begin
            put       = 1'b1;
            lit_rem_d = lit_rem_q - 1'b1;
            s1_load   = 1'b1;
            s1_d.wr_en    = 1'b1;
            s1_d.lit_byte = in_data_i.in_byte;
            s1_d.status   = ST_DATA;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    wp_d = wp_q;
    bw_d = bw_q;
    if (put) begin
      wp_d = wp_inc;
      if (bw_q != BW'(HISTORY_DEPTH)) begin
        bw_d = bw_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q    <= '0;
      consumed_q  <= '0;
      wp_q        <= '0;
      src_q       <= '0;
      bw_q        <= '0;
      phase_q     <= PH_HDR0;
      hdist_q     <= '0;
      hlen_lo_q   <= '0;
      lit_rem_q   <= '0;
      copy_rem_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stream_q <= cfg_wdata_i;
      end
      consumed_q <= consumed_d;
      wp_q       <= wp_d;
      src_q      <= src_d;
      bw_q       <= bw_d;
      phase_q    <= phase_d;
      hdist_q    <= hdist_d;
      hlen_lo_q  <= hlen_lo_d;
      lit_rem_q  <= lit_rem_d;
      copy_rem_q <= copy_rem_d;
      if (s1_free) begin
        s1_valid_q <= s1_load;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q      <= s1_d;
      wr_addr_q <= wp_q;
    end
    if (mem_rd_en) begin
      fwd_data_q <= s1_val;
    end
    if (out_free && s1_valid_q) begin
      out_data_q.out_byte <= s1_val;
      out_data_q.status   <= s1_q.status;
    end
  end

  // History memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_now) begin
      hist_mem_q[wr_addr_q] <= s1_val;
    end
    if (mem_rd_en) begin
      rd_data_q <= hist_mem_q[src_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "lz77_token_decompressor_assert.svh"

  `LZD_ASSERT_IMPL(a_copy_at_header_start, copy_rem_q != '0, phase_q == PH_HDR0,
                   "copy pending outside the first header phase")
  `LZD_ASSERT_IMPL(a_lit_count_live, phase_q == PH_LIT, lit_rem_q != '0,
                   "literal phase with no literal bytes left")
  `LZD_ASSERT_IMPL(a_window_bound, 1'b1, bw_q <= BW'(HISTORY_DEPTH),
                   "written byte count exceeds the history depth")
  `LZD_ASSERT_NEXT(a_read_feeds_copy, mem_rd_en, s1_valid_q && s1_q.is_copy && s1_q.wr_en,
                   "history read not followed by a copy write-back stage")

endmodule
